FILE: hdl/lct_pkg.sv
// Shared types and constants for the LFU cache table.
`default_nettype none
package lct_pkg;

  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE = '0;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Search token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic              v;
    logic              found;
    logic [IDX_W-1:0]  hit_idx;
    logic [DATA_W-1:0] hit_val;
    logic [IDX_W-1:0]  hit_rank;
    logic              have;
    logic [IDX_W-1:0]  vic_idx;
    logic [CNT_W-1:0]  vic_cnt;
    logic [IDX_W-1:0]  vic_rank;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } tok_t;

  // Update broadcast to all cells at the end of a scan.
  typedef struct packed {
    logic              apply;
    logic              insert;
    logic              gap_en;
    logic [IDX_W-1:0]  gap_rank;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  new_rank;
    logic              wr_val;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/lct_cell.sv
// One cache entry cell that also advances the search token to its neighbor.
`default_nettype none
module lct_cell import lct_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned RANK_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [DATA_W-1:0] skey_i,
  input  wire tok_t              tok_i,
  output tok_t                   tok_o,
  input  wire cmd_t              cmd_i
);

  logic                   valid_q, valid_d;
  logic [DATA_W-1:0]      key_q, key_d;
  logic [DATA_W-1:0]      value_q, value_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [RANK_W-1:0]      rank_q, rank_d;
  tok_t                   tok_q, tok_d;
  logic [CNT_W-1:0]       cnt_ext;
  logic [IDX_W-1:0]       rank_ext;
  logic                   sel;

  assign cnt_ext  = CNT_W'(count_q);
  assign rank_ext = IDX_W'(rank_q);
  assign sel      = (cmd_i.slot == IDX_W'(INDEX));

  always_comb begin
    tok_d = tok_i;
    if (tok_i.v && valid_q) begin
      if (!tok_i.found && key_q == skey_i) begin
        tok_d.found    = 1'b1;
        tok_d.hit_idx  = IDX_W'(INDEX);
        tok_d.hit_val  = value_q;
        tok_d.hit_rank = rank_ext;
      end
      if (!tok_i.have || cnt_ext < tok_i.vic_cnt ||
          (cnt_ext == tok_i.vic_cnt && rank_ext < tok_i.vic_rank)) begin
        tok_d.have     = 1'b1;
        tok_d.vic_idx  = IDX_W'(INDEX);
        tok_d.vic_cnt  = cnt_ext;
        tok_d.vic_rank = rank_ext;
      end
    end
    if (tok_i.v && !valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = IDX_W'(INDEX);
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    rank_d  = rank_q;
    if (cmd_i.apply) begin
      if (valid_q && cmd_i.gap_en && rank_ext > cmd_i.gap_rank) begin
        rank_d = rank_q - RANK_W'(1);
      end
      if (sel) begin
        rank_d = cmd_i.new_rank[RANK_W-1:0];
        if (cmd_i.insert) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          value_d = cmd_i.value;
          count_d = COUNT_WIDTH'(1);
        end else begin
          if (count_q != '1) begin
            count_d = count_q + COUNT_WIDTH'(1);
          end
          if (cmd_i.wr_val) begin
            value_d = cmd_i.value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

FILE: hdl/lfu_cache_table.sv
// Top level of the LFU cache table with recency tie break.
//
// Channel  Direction  Signals
// in       input      in_valid_i, in_ready_o, func_i, lookup_key_i, write_value_i
// out      output     out_valid_o, out_ready_i, hit_o, read_value_o
// cfg      input      cfg_valid_i, cfg_ready_o, capacity_in_use_i
//
// A request is scanned by a search token that passes one cell per cycle, so the row
// length sets the time from acceptance to result. With zero capacity the result is
// ready in the cycle after acceptance. Reset clears all entries at once.
// A waiting result holds the block until it is taken.
`default_nettype none
module lfu_cache_table import lct_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              func_i,
  input  wire logic [31:0]       lookup_key_i,
  input  wire logic [31:0]       write_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   hit_o,
  output logic [31:0]            read_value_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CAP_W-1:0]  capacity_in_use_i
);

  localparam int unsigned RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              start_q, start_d;
  logic              func_q;
  logic [DATA_W-1:0] key_q, val_q;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [EXT_W-1:0]  cap_ext, cap_eff;
  logic              full;
  logic              accept;
  tok_t              tok_w [CAPACITY+1];
  tok_t              last;
  cmd_t              cmd;
  logic [CAPACITY:0] tok_v;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_DONE);
  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;
  assign accept       = in_valid_i && in_ready_o;
  assign cap_ext      = EXT_W'(cap_q);
  assign cap_eff      = (cap_ext > EXT_W'(CAPACITY)) ? EXT_W'(CAPACITY) : cap_ext;
  assign full         = EXT_W'(occ_q) >= cap_eff;
  assign last         = tok_w[CAPACITY];

  always_comb begin
    tok_w[0]   = '0;
    tok_w[0].v = start_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lct_cell #(
      .INDEX(g),
      .COUNT_WIDTH(COUNT_WIDTH),
      .RANK_W(RANK_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .skey_i(key_q),
      .tok_i (tok_w[g]),
      .tok_o (tok_w[g+1]),
      .cmd_i (cmd)
    );
  end

  for (genvar g = 0; g <= CAPACITY; g++) begin : g_tv
    assign tok_v[g] = tok_w[g].v;
  end

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    start_d = 1'b0;
    hit_d   = hit_q;
    rdata_d = rdata_q;
    cmd     = '0;
    cmd.key   = key_q;
    cmd.value = val_q;
    cmd.wr_val = (func_q == FUNC_PUT);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cap_q == '0) begin
            hit_d   = 1'b0;
            rdata_d = (func_i == FUNC_PUT) ? PUT_VALUE : MISS_VALUE;
            state_d = ST_DONE;
          end else begin
            start_d = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last.v) begin
          state_d = ST_DONE;
          if (last.found) begin
            hit_d        = 1'b1;
            rdata_d      = (func_q == FUNC_PUT) ? PUT_VALUE : last.hit_val;
            cmd.apply    = 1'b1;
            cmd.gap_en   = 1'b1;
            cmd.gap_rank = last.hit_rank;
            cmd.slot     = last.hit_idx;
            cmd.new_rank = IDX_W'(occ_q) - IDX_W'(1);
          end else begin
            hit_d   = 1'b0;
            rdata_d = (func_q == FUNC_PUT) ? PUT_VALUE : MISS_VALUE;
            if (func_q == FUNC_PUT) begin
              cmd.apply  = 1'b1;
              cmd.insert = 1'b1;
              if (full) begin
                cmd.gap_en   = 1'b1;
                cmd.gap_rank = last.vic_rank;
                cmd.slot     = last.vic_idx;
                cmd.new_rank = IDX_W'(occ_q) - IDX_W'(1);
              end else begin
                cmd.slot     = last.free_idx;
                cmd.new_rank = IDX_W'(occ_q);
                occ_d        = occ_q + OCC_W'(1);
              end
            end
          end
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      occ_q   <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      start_q <= start_d;
      if (cfg_valid_i) begin
        cap_q <= capacity_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    rdata_q <= rdata_d;
    if (accept) begin
      func_q <= func_i;
      key_q  <= lookup_key_i;
      val_q  <= write_value_i;
    end
  end

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_v)) else $error("more than one search token in the row");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EXT_W'(occ_q) <= EXT_W'(CAPACITY)) else $error("occupancy above capacity");

  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o) else $error("no return to idle");

  a_token_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.v |-> state_q == ST_SCAN) else $error("token outside a scan");

endmodule
`default_nettype wire

FILE: dv/lfu_cache_table_test.sv
// Self-checking testbench for the LFU cache table with an internal prediction model.
`default_nettype none
module lfu_cache_table_test;
  import lct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned CMAX = 16'hFFFF;
  localparam int unsigned LIMIT = 2000000;

  typedef struct {
    func_e       func;
    logic [31:0] key;
    logic [31:0] val;
  } request_t;

  typedef struct {
    logic        hit;
    logic [31:0] val;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = 1'b0;
  logic [31:0] lookup_key_i = '0;
  logic [31:0] write_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [31:0] read_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CAP_W-1:0] capacity_in_use_i = '0;

  lfu_cache_table DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .lookup_key_i, .write_value_i,
    .out_valid_o, .out_ready_i, .hit_o, .read_value_o,
    .cfg_valid_i, .cfg_ready_o, .capacity_in_use_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted cache contents.
  logic        m_valid [SLOTS];
  logic [31:0] m_key [SLOTS];
  logic [31:0] m_val [SLOTS];
  int unsigned m_cnt [SLOTS];
  int unsigned m_rank [SLOTS];
  int unsigned m_used;
  int unsigned m_cap;

  request_t pending_q[$];
  answer_t  answer_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned accepted = 0;
  int unsigned total = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  function automatic void close_rank(int unsigned r);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
  endfunction

  function automatic answer_t predict_lookup(request_t rq);
    answer_t a;
    int unsigned cap;
    int match;
    int slot;
    cap = (m_cap > SLOTS) ? SLOTS : m_cap;
    match = -1;
    slot = -1;
    a.hit = 1'b0;
    a.val = (rq.func == FUNC_PUT) ? PUT_VALUE : MISS_VALUE;
    if (cap == 0) return a;
    for (int i = 0; i < SLOTS; i++)
      if (match < 0 && m_valid[i] && m_key[i] == rq.key) match = i;
    if (match >= 0) begin
      a.hit = 1'b1;
      if (rq.func == FUNC_PUT) m_val[match] = rq.val;
      else a.val = m_val[match];
      close_rank(m_rank[match]);
      m_rank[match] = m_used - 1;
      if (m_cnt[match] < CMAX) m_cnt[match]++;
      return a;
    end
    if (rq.func == FUNC_GET) return a;
    if (m_used >= cap) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!m_valid[i]) continue;
        if (slot < 0 || m_cnt[i] < m_cnt[slot] ||
            (m_cnt[i] == m_cnt[slot] && m_rank[i] < m_rank[slot])) slot = i;
      end
      if (slot >= 0) begin
        m_valid[slot] = 1'b0;
        close_rank(m_rank[slot]);
        m_used--;
      end
    end
    if (slot < 0)
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !m_valid[i]) slot = i;
    if (slot < 0) return a;
    m_valid[slot] = 1'b1;
    m_key[slot] = rq.key;
    m_val[slot] = rq.val;
    m_cnt[slot] = 1;
    m_rank[slot] = m_used;
    m_used++;
    return a;
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        answer_q.push_back(predict_lookup(pending_q.pop_front()));
        accepted++;
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!in_quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 16);
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > (in_valid_i && in_ready_o ? 0 : 0)) begin
        in_valid_i <= 1'b1;
        func_i <= pending_q[0].func;
        lookup_key_i <= pending_q[0].key;
        write_value_i <= pending_q[0].val;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          $error("Unexpected result: hit %0b value %0h", hit_o, read_value_o);
          errors++;
        end else begin
          answer_t e;
          e = answer_q.pop_front();
          if (hit_o !== e.hit) begin
            $error("hit: expected %0b, actual %0b", e.hit, hit_o);
            errors++;
          end
          if (read_value_o !== e.val) begin
            $error("read_value: expected %0h, actual %0h", e.val, read_value_o);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!out_quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_request(func_e f, logic [31:0] k, logic [31:0] v);
    request_t rq;
    rq.func = f;
    rq.key = k;
    rq.val = v;
    pending_q.push_back(rq);
    total++;
  endtask

  task automatic wait_drained();
    while (accepted < total || answer_q.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    capacity_in_use_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_cap = 32'(c);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly keys from a small pool so hits, updates and evictions are common.
  task automatic random_phase(int unsigned n, int unsigned pool);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = 32'h8000_0000 ^ $urandom_range(0, pool - 1);
      add_request($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, k, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      m_valid[i] = 1'b0;
      m_key[i] = '0;
      m_val[i] = '0;
      m_cnt[i] = 0;
      m_rank[i] = 0;
    end
    m_used = 0;
    m_cap = 32'(CAP_RESET);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_request(FUNC_GET, 32'h0, 32'h0);
    add_request(FUNC_PUT, 32'h0, 32'hFFFF_FFFF);
    add_request(FUNC_GET, 32'h0, 32'h1234_5678);
    add_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0);
    add_request(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
    add_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
    add_request(FUNC_GET, 32'hFFFF_FFFF, 32'hAAAA_5555);
    for (int i = 0; i < 14; i++) add_request(FUNC_PUT, 32'h100 + i, i);
    add_request(FUNC_GET, 32'h8000_0000, 32'h0);
    wait_drained();

    set_capacity(5'd2);
    random_phase(60, 4);
    wait_drained();
    set_capacity(5'd0);
    random_phase(30, 4);
    wait_drained();
    set_capacity(5'd31);
    random_phase(200, 24);
    wait_drained();
    set_capacity(5'd1);
    random_phase(80, 3);
    wait_drained();
    set_capacity(5'd8);
    random_phase(250, 14);
    wait_drained();
    set_capacity(5'd16);
    random_phase(150, 22);
    wait_drained();
    in_quiet = 1'b1;
    out_quiet = 1'b1;
    random_phase(150, 20);
    wait_drained();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
